@@ design/lpfr_pkg.sv @@
// ----------------------------------------------------------------------------
// lpfr_pkg
// Shared types, codes and the CRC-16 update for the frame receiver.
// ----------------------------------------------------------------------------
package lpfr_pkg;

    // Width of the big-endian length field (up to three length bytes)
    localparam int LEN_FIELD_W = 24;

    localparam logic [LEN_FIELD_W-1:0] MAX_LEN_RESET = 24'd512;

    localparam logic [7:0]  START_MIN = 8'd2;
    localparam logic [7:0]  START_MAX = 8'd4;
    localparam logic [7:0]  END_BYTE  = 8'd3;
    localparam logic [15:0] CRC_POLY  = 16'h1021;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    localparam logic [1:0] STATUS_GOOD     = 2'd0;
    localparam logic [1:0] STATUS_BAD_CRC  = 2'd1;
    localparam logic [1:0] STATUS_BAD_END  = 2'd2;
    localparam logic [1:0] STATUS_TOO_LONG = 2'd3;

    typedef struct packed {
        logic       valid;
        logic       kind;
        logic [7:0] data;
        logic [1:0] status;
        logic       last;
    } lpfr_result_t;

    // CRC-16/XMODEM, one byte, MSB first
    function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                 input logic [7:0]  data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

@@ design/lpfr_parser.sv @@
// ----------------------------------------------------------------------------
// lpfr_parser
// Frame phase tracking, length decode, CRC accumulation and result build.
// ----------------------------------------------------------------------------
module lpfr_parser #(
    parameter int LENGTH_WIDTH = 24
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            step_en,
    input  logic [7:0]                      rx_byte,
    input  logic [lpfr_pkg::LEN_FIELD_W-1:0] max_len,
    output lpfr_pkg::lpfr_result_t          result
);
    import lpfr_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN,
        PH_PAYLOAD,
        PH_CRC_HI,
        PH_CRC_LO,
        PH_END
    } phase_t;

    phase_t                  phase_reg,     phase_next;
    logic [1:0]              len_left_reg,  len_left_next;
    logic [LEN_FIELD_W-1:0]  length_reg,    length_next;
    logic [LENGTH_WIDTH-1:0] remaining_reg, remaining_next;
    logic [15:0]             crc_reg,       crc_next;
    logic [15:0]             rx_crc_reg,    rx_crc_next;

    logic [LEN_FIELD_W-1:0]  length_acc;
    logic                    too_long;

    assign length_acc = {length_reg[LEN_FIELD_W-9:0], rx_byte};
    assign too_long   = (length_acc > max_len) ||
                        ((length_acc >> LENGTH_WIDTH) != '0);

    always_comb begin
        phase_next     = phase_reg;
        len_left_next  = len_left_reg;
        length_next    = length_reg;
        remaining_next = remaining_reg;
        crc_next       = crc_reg;
        rx_crc_next    = rx_crc_reg;
        result         = '0;

        unique case (phase_reg)
            PH_HUNT: begin
                if (rx_byte >= START_MIN && rx_byte <= START_MAX) begin
                    len_left_next  = 2'(rx_byte - 8'd1);
                    length_next    = '0;
                    remaining_next = '0;
                    crc_next       = '0;
                    rx_crc_next    = '0;
                    phase_next     = PH_LEN;
                end
            end
            PH_LEN: begin
                length_next   = length_acc;
                len_left_next = len_left_reg - 2'd1;
                if (len_left_reg == 2'd1) begin
                    if (too_long) begin
                        // reject and resync without consuming CRC or end byte
                        phase_next    = PH_HUNT;
                        len_left_next = 2'd0;
                        result.valid  = 1'b1;
                        result.kind   = KIND_STATUS;
                        result.status = STATUS_TOO_LONG;
                        result.last   = 1'b1;
                    end else begin
                        remaining_next = length_acc[LENGTH_WIDTH-1:0];
                        phase_next     = (length_acc == '0) ? PH_CRC_HI : PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                crc_next       = crc16_update(crc_reg, rx_byte);
                remaining_next = remaining_reg - LENGTH_WIDTH'(1);
                if (remaining_reg == LENGTH_WIDTH'(1)) begin
                    phase_next = PH_CRC_HI;
                end
                result.valid = 1'b1;
                result.kind  = KIND_PAYLOAD;
                result.data  = rx_byte;
            end
            PH_CRC_HI: begin
                rx_crc_next = {rx_byte, 8'h00};
                phase_next  = PH_CRC_LO;
            end
            PH_CRC_LO: begin
                rx_crc_next = {rx_crc_reg[15:8], rx_byte};
                phase_next  = PH_END;
            end
            PH_END: begin
                phase_next    = PH_HUNT;
                len_left_next = 2'd0;
                result.valid  = 1'b1;
                result.kind   = KIND_STATUS;
                result.last   = 1'b1;
                // bad end byte wins over a CRC mismatch
                if (rx_byte != END_BYTE) begin
                    result.status = STATUS_BAD_END;
                end else if (rx_crc_reg != crc_reg) begin
                    result.status = STATUS_BAD_CRC;
                end else begin
                    result.status = STATUS_GOOD;
                end
            end
            default: begin
                phase_next    = PH_HUNT;
                len_left_next = 2'd0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HUNT;
            len_left_reg  <= 2'd0;
            length_reg    <= '0;
            remaining_reg <= '0;
            crc_reg       <= '0;
            rx_crc_reg    <= '0;
        end else if (step_en) begin
            phase_reg     <= phase_next;
            len_left_reg  <= len_left_next;
            length_reg    <= length_next;
            remaining_reg <= remaining_next;
            crc_reg       <= crc_next;
            rx_crc_reg    <= rx_crc_next;
        end
    end

endmodule

@@ design/lpfr_out_reg.sv @@
// ----------------------------------------------------------------------------
// lpfr_out_reg
// Result register toward the output channel.
// ----------------------------------------------------------------------------
module lpfr_out_reg (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  lpfr_pkg::lpfr_result_t result,
    output logic                   free,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_result_kind,
    output logic [7:0]             m_payload_byte,
    output logic [1:0]             m_frame_status,
    output logic                   m_frame_last
);
    import lpfr_pkg::*;

    logic       valid_reg;
    logic       kind_reg;
    logic [7:0] data_reg;
    logic [1:0] status_reg;
    logic       last_reg;

    assign free = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg   <= result.kind;
            data_reg   <= result.data;
            status_reg <= result.status;
            last_reg   <= result.last;
        end
    end

    assign m_valid        = valid_reg;
    assign m_result_kind  = kind_reg;
    assign m_payload_byte = data_reg;
    assign m_frame_status = status_reg;
    assign m_frame_last   = last_reg;

endmodule

@@ design/length_prefixed_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// length_prefixed_frame_receiver
// Byte-serial receiver for length-prefixed frames with CRC-16/XMODEM.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_rx_byte carry the received byte stream, one byte per
//   request. m_* carries results: payload bytes as they arrive (kind 0) and
//   one status per frame (kind 1, frame_last set). cfg_valid/cfg_ready/
//   cfg_data writes the maximum payload length; cfg_ready is always high.
//   Path: a byte is taken into the input register and its result leaves
//   through the result register.
//   Throughput: one byte per cycle unless m_ready stalls; the phase step
//   and CRC update sit between the input register and the result register.
//   Reset (aresetn low, synchronous): hunting for a start byte, both
//   registers empty, maximum length back to 512.
//   Stall: while m_ready is low, bytes that produce no result keep flowing;
//   a byte whose result finds the result register full waits in the input
//   register, and s_ready drops once both registers are occupied.
// ----------------------------------------------------------------------------
module length_prefixed_frame_receiver #(
    parameter int LENGTH_WIDTH = 24
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_rx_byte,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_result_kind,
    output logic [7:0]                       m_payload_byte,
    output logic [1:0]                       m_frame_status,
    output logic                             m_frame_last,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lpfr_pkg::LEN_FIELD_W-1:0] cfg_data
);
    import lpfr_pkg::*;

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic [LEN_FIELD_W-1:0] max_len_reg;
    lpfr_result_t           result;
    logic                   out_free;
    logic                   advance;

    // advance the held byte unless its result has nowhere to go
    assign advance   = in_valid_reg && (!result.valid || out_free);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAX_LEN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            max_len_reg <= cfg_data;
        end
    end

    lpfr_parser #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .rx_byte (in_byte_reg),
        .max_len (max_len_reg),
        .result  (result)
    );

    lpfr_out_reg u_out_reg (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (advance && result.valid),
        .result         (result),
        .free           (out_free),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_payload_byte (m_payload_byte),
        .m_frame_status (m_frame_status),
        .m_frame_last   (m_frame_last)
    );

endmodule

@@ design/lpfr_checker.sv @@
// ----------------------------------------------------------------------------
// lpfr_checker
// Port-level checks on the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module lpfr_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_result_kind,
    input logic [7:0] m_payload_byte,
    input logic [1:0] m_frame_status,
    input logic       m_frame_last
);
    import lpfr_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_kind) &&
        $stable(m_payload_byte) && $stable(m_frame_status) && $stable(m_frame_last))
        else $error("stalled result changed");

    a_status_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == KIND_STATUS |-> m_frame_last && m_payload_byte == 8'd0)
        else $error("status result malformed");

    a_payload_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == KIND_PAYLOAD |->
        !m_frame_last && m_frame_status == STATUS_GOOD)
        else $error("payload result malformed");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind length_prefixed_frame_receiver lpfr_checker u_lpfr_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_result_kind  (m_result_kind),
    .m_payload_byte (m_payload_byte),
    .m_frame_status (m_frame_status),
    .m_frame_last   (m_frame_last)
);

@@ tb/length_prefixed_frame_receiver_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_frame_receiver_test
// Self-checking bench for the length-prefixed frame receiver. A frame decoder
// in the bench tracks every accepted byte and queues the payload and status
// results it implies. Results are compared in order as they leave the block.
// Covered: directed framing cases, maximum length limits and random frame
// streams with random gaps and back-pressure.
// ----------------------------------------------------------------------------
module length_prefixed_frame_receiver_test;
    import lpfr_pkg::*;

    localparam int          MAX_GAP      = 12;
    localparam int          RANDOM_BYTES = 770;
    localparam logic [23:0] MAX_LEN_TOP  = 24'hFFFFFF;

    typedef enum logic [2:0] {
        RX_HUNT,
        RX_LENGTH,
        RX_PAYLOAD,
        RX_CRC_HI,
        RX_CRC_LO,
        RX_END_BYTE
    } rx_phase_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic [1:0] status;
        logic       last;
    } rx_result_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic        m_result_kind;
    logic [7:0]  m_payload_byte;
    logic [1:0]  m_frame_status;
    logic        m_frame_last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [23:0] cfg_data  = 24'd0;

    // Frame decoder state
    rx_phase_t   rx_phase       = RX_HUNT;
    int unsigned len_bytes_left = 0;
    logic [23:0] frame_len      = 24'd0;
    logic [23:0] bytes_left     = 24'd0;
    logic [15:0] crc_acc        = 16'h0000;
    logic [15:0] crc_rx         = 16'h0000;
    logic [23:0] max_len        = MAX_LEN_RESET;

    rx_result_t  frame_results[$];
    int unsigned bytes_used     = 0;
    int unsigned mismatch_count = 0;
    bit          quiet_sender   = 1'b0;
    bit          quiet_receiver = 1'b0;

    length_prefixed_frame_receiver dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_payload_byte (m_payload_byte),
        .m_frame_status (m_frame_status),
        .m_frame_last   (m_frame_last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    always #6 aclk = ~aclk;

    // CRC-16/XMODEM, one data bit at a time, MSB first
    function automatic logic [15:0] crc16_step(input logic [15:0] crc,
                                               input logic [7:0]  b);
        logic [15:0] r;
        logic        fb;
        r = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[15] ^ b[i];
            r  = {r[14:0], 1'b0};
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        rx_result_t res;
        res = '{kind: KIND_STATUS, data: 8'h00, status: STATUS_GOOD, last: 1'b1};
        if (!(rx_phase == RX_HUNT && (b < START_MIN || b > START_MAX))) begin
            bytes_used++;
        end
        case (rx_phase)
            RX_HUNT: begin
                if (b >= START_MIN && b <= START_MAX) begin
                    len_bytes_left = int'(b) - 1;
                    frame_len      = 24'd0;
                    bytes_left     = 24'd0;
                    crc_acc        = 16'h0000;
                    crc_rx         = 16'h0000;
                    rx_phase       = RX_LENGTH;
                end
            end
            RX_LENGTH: begin
                frame_len = {frame_len[15:0], b};
                len_bytes_left--;
                if (len_bytes_left == 0) begin
                    if (frame_len > max_len) begin
                        res.status = STATUS_TOO_LONG;
                        frame_results.push_back(res);
                        rx_phase = RX_HUNT;
                    end else begin
                        bytes_left = frame_len;
                        if (frame_len == 24'd0) begin
                            rx_phase = RX_CRC_HI;
                        end else begin
                            rx_phase = RX_PAYLOAD;
                        end
                    end
                end
            end
            RX_PAYLOAD: begin
                crc_acc    = crc16_step(crc_acc, b);
                bytes_left = bytes_left - 24'd1;
                if (bytes_left == 24'd0) begin
                    rx_phase = RX_CRC_HI;
                end
                res = '{kind: KIND_PAYLOAD, data: b, status: STATUS_GOOD, last: 1'b0};
                frame_results.push_back(res);
            end
            RX_CRC_HI: begin
                crc_rx   = {b, 8'h00};
                rx_phase = RX_CRC_LO;
            end
            RX_CRC_LO: begin
                crc_rx[7:0] = b;
                rx_phase    = RX_END_BYTE;
            end
            default: begin
                // a bad end byte outranks a CRC mismatch
                if (b != END_BYTE) begin
                    res.status = STATUS_BAD_END;
                end else if (crc_rx != crc_acc) begin
                    res.status = STATUS_BAD_CRC;
                end
                frame_results.push_back(res);
                rx_phase = RX_HUNT;
            end
        endcase
    endfunction

    task automatic send_rx_byte(input logic [7:0] b);
        int gap;
        gap = quiet_sender ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        decode_byte(b);
    endtask

    // Drop valid, let every queued result arrive, then let the pipeline settle
    task automatic wait_all_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (frame_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_max_length(input logic [23:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        max_len = value;
        @(posedge aclk);
    endtask

    // Send a frame with random payload; stop early when truncated or too long
    task automatic send_frame(input int unsigned n_len, input logic [23:0] len,
                              input logic [15:0] crc_flip, input logic [7:0] end_byte,
                              input bit truncate);
        logic [15:0] crc;
        logic [7:0]  b;
        int unsigned keep;
        send_rx_byte(8'(n_len + 1));
        for (int i = int'(n_len) - 1; i >= 0; i--) begin
            send_rx_byte(len[8*i +: 8]);
        end
        if (len > max_len) begin
            return;
        end
        keep = (truncate && len != 24'd0) ? $urandom_range(0, int'(len) - 1) : int'(len);
        crc  = 16'h0000;
        for (int unsigned k = 0; k < keep; k++) begin
            b   = 8'($urandom);
            crc = crc16_step(crc, b);
            send_rx_byte(b);
        end
        if (keep != int'(len)) begin
            return;
        end
        crc = crc ^ crc_flip;
        send_rx_byte(crc[15:8]);
        send_rx_byte(crc[7:0]);
        send_rx_byte(end_byte);
    endtask

    task automatic test_frame_cases();
        send_rx_byte(8'h00);
        send_rx_byte(8'hFF);
        // empty payload: CRC must be zero
        send_frame(1, 24'd0, 16'h0000, END_BYTE, 1'b0);
        send_frame(2, 24'd1, 16'hFFFF, 8'h00, 1'b0);
        send_frame(3, MAX_LEN_TOP, 16'h0000, END_BYTE, 1'b0);
        send_frame(1, 24'd2, 16'h8001, END_BYTE, 1'b0);
        wait_all_results();
    endtask

    task automatic test_length_limit();
        write_max_length(24'd0);
        send_frame(1, 24'd1, 16'h0000, END_BYTE, 1'b0);
        send_frame(1, 24'd0, 16'h0000, END_BYTE, 1'b0);
        wait_all_results();
        write_max_length(24'd5);
        send_frame(2, 24'd5, 16'h0000, END_BYTE, 1'b0);
        send_frame(1, 24'd6, 16'h0000, END_BYTE, 1'b0);
        wait_all_results();
        write_max_length(MAX_LEN_TOP);
        send_frame(3, 24'd3, 16'h0000, END_BYTE, 1'b0);
        // limit changed between the length bytes of one frame
        send_rx_byte(8'h03);
        send_rx_byte(8'h00);
        wait_all_results();
        write_max_length(24'd4);
        send_rx_byte(8'h05);
        wait_all_results();
        write_max_length(MAX_LEN_RESET);
    endtask

    task automatic test_random_streams();
        int unsigned target;
        int unsigned frames;
        int unsigned r;
        int unsigned cap;
        int unsigned need;
        logic [23:0] len;
        logic [23:0] limit;
        logic [15:0] flip;
        logic [7:0]  b;
        target = bytes_used + RANDOM_BYTES;
        frames = 0;
        while (bytes_used < target) begin
            if (frames % 24 == 0) begin
                wait_all_results();
                quiet_sender   = ($urandom_range(0, 3) == 0);
                quiet_receiver = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 1) == 1) begin
                    case ($urandom_range(0, 4))
                        0:       limit = 24'd0;
                        1:       limit = 24'($urandom_range(1, 40));
                        2:       limit = MAX_LEN_RESET;
                        3:       limit = MAX_LEN_TOP;
                        default: limit = 24'($urandom);
                    endcase
                    write_max_length(limit);
                end
            end
            frames++;
            r = $urandom_range(0, 99);
            if (r < 10) begin
                // noise between frames; keep clear of start bytes
                repeat ($urandom_range(1, 5)) begin
                    b = 8'($urandom);
                    if (b >= START_MIN && b <= START_MAX) begin
                        b = b ^ 8'h80;
                    end
                    send_rx_byte(b);
                end
            end else begin
                cap = ($urandom_range(0, 19) == 0) ? 60 : 12;
                if (max_len < 24'(cap)) begin
                    cap = int'(max_len);
                end
                if (r < 20 && max_len != MAX_LEN_TOP) begin
                    if (max_len > MAX_LEN_TOP - 24'd301) begin
                        len = MAX_LEN_TOP;
                    end else begin
                        len = max_len + 24'd1 + 24'($urandom_range(0, 300));
                    end
                end else begin
                    len = 24'($urandom_range(0, cap));
                end
                need = (len > 24'hFFFF) ? 3 : ((len > 24'hFF) ? 2 : 1);
                flip = ($urandom_range(0, 6) == 0) ? 16'($urandom_range(1, 16'hFFFF)) : 16'h0;
                b    = ($urandom_range(0, 6) == 0) ? 8'($urandom) : END_BYTE;
                send_frame($urandom_range(need, 3), len, flip, b,
                           (max_len <= MAX_LEN_RESET) && ($urandom_range(0, 24) == 0));
            end
        end
    endtask

    // Result side: random stalls, in-order compare
    initial begin
        int         stall;
        rx_result_t want;
        wait (aresetn === 1'b1);
        forever begin
            stall = quiet_receiver ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            if (frame_results.size() == 0) begin
                if (mismatch_count < 10) begin
                    $display("unexpected result: kind %0d data %02h status %0d last %0d",
                             m_result_kind, m_payload_byte, m_frame_status, m_frame_last);
                end
                mismatch_count++;
            end else begin
                want = frame_results.pop_front();
                if (m_result_kind !== want.kind || m_payload_byte !== want.data ||
                    m_frame_status !== want.status || m_frame_last !== want.last) begin
                    if (mismatch_count < 10) begin
                        $display("mismatch: kind %0d/%0d data %02h/%02h status %0d/%0d last %0d/%0d",
                                 want.kind, m_result_kind, want.data, m_payload_byte,
                                 want.status, m_frame_status, want.last, m_frame_last);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_frame_cases();
        test_length_limit();
        test_random_streams();
        wait_all_results();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && frame_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
